FILE: rtl/shw_pkg.sv
// ----------------------------------------------------------------------------
// shw_pkg: shared types and constants of the spelling word hash
// Widths, the character code table and the command passed from the front
// end to the arithmetic back end.
// ----------------------------------------------------------------------------
package shw_pkg;

   localparam int HASH_W       = 27;
   localparam int MOD_W        = HASH_W + 1;
   localparam int MAX_WORD_LEN = 30;
   localparam int CNT_W        = $clog2(MAX_WORD_LEN + 1);

   localparam logic [HASH_W-1:0] POWER_INIT = HASH_W'(1) << (HASH_W - 8);
   localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(134217689);
   localparam logic [MOD_W-1:0]  MOD_MAX    = MOD_W'(1) << HASH_W;
   localparam logic [MOD_W-1:0]  MOD_MIN    = MOD_W'(2);

   // dividend width of the remainder unit, two bits retired per cycle
   localparam int DIV_W     = 2 * ((HASH_W + 5) / 2);
   localparam int RED_STEPS = DIV_W / 2;
   localparam int STEP_W    = $clog2(RED_STEPS);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

   localparam logic [7:0] NO_CODE    = 8'hFF;
   localparam logic [7:0] FIRST_CHAR = 8'h20;
   localparam int         TABLE_LEN  = 96;
   localparam int         TABLE_AW   = $clog2(TABLE_LEN);

   // codes for space up to DEL, NO_CODE marks a gap
   localparam logic [7:0] CODE_TABLE [TABLE_LEN] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd31,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd68,  8'd255, 8'd65,  8'd255,
      8'd2,   8'd25,  8'd20,  8'd35,  8'd54,  8'd61,  8'd40,  8'd39,
      8'd42,  8'd33,  8'd64,  8'd67,  8'd255, 8'd255, 8'd255, 8'd66,
      8'd255, 8'd60,  8'd43,  8'd30,  8'd5,   8'd16,  8'd47,  8'd18,
      8'd41,  8'd36,  8'd51,  8'd6,   8'd13,  8'd56,  8'd55,  8'd58,
      8'd49,  8'd12,  8'd59,  8'd46,  8'd21,  8'd32,  8'd63,  8'd34,
      8'd57,  8'd52,  8'd3,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd22,  8'd29,  8'd8,   8'd7,   8'd10,  8'd1,   8'd28,
      8'd11,  8'd62,  8'd37,  8'd48,  8'd15,  8'd50,  8'd9,   8'd4,
      8'd19,  8'd38,  8'd45,  8'd24,  8'd23,  8'd26,  8'd17,  8'd44,
      8'd27,  8'd14,  8'd53,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef struct packed {
      logic       do_hash;
      logic [2:0] code_low;
      logic [3:0] code_high;
      logic       last;
      logic       bad;
      logic       too_long;
   } cmd_type;

endpackage

FILE: rtl/shw_front.sv
// ----------------------------------------------------------------------------
// shw_front: character intake and classification
// Looks up the character code, tracks the length and error flags of the
// current word and hands one command per character to the command queue.
// ----------------------------------------------------------------------------
module shw_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [7:0]       req_char_code,
   input  logic             req_last_char,
   input  logic             q_full,
   output logic             q_wr,
   output shw_pkg::cmd_type q_entry
);
   import shw_pkg::*;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic                bad_ff, bad_in;
   logic                long_ff, long_in;
   logic                in_range;
   logic [TABLE_AW-1:0] tab_idx;
   logic [7:0]          code;
   logic                coded;
   logic                at_limit;
   logic                accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_wr     = accept;

   assign in_range = !req_char_code[7] && (req_char_code[6:5] != 2'b00);
   assign tab_idx  = TABLE_AW'(req_char_code[6:0] - FIRST_CHAR[6:0]);
   assign code     = in_range ? CODE_TABLE[tab_idx] : NO_CODE;
   assign coded    = (code != NO_CODE);
   assign at_limit = (count_ff >= CNT_W'(MAX_WORD_LEN));

   always_comb begin
      bad_in   = bad_ff | !coded;
      long_in  = long_ff | (coded && at_limit);
      count_in = count_ff;
      if (coded && !at_limit) begin
         count_in = count_ff + 1'b1;
      end

      q_entry.do_hash   = coded && !at_limit;
      q_entry.code_low  = code[2:0];
      q_entry.code_high = code[6:3];
      q_entry.last      = req_last_char;
      q_entry.bad       = bad_in;
      q_entry.too_long  = long_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bad_ff   <= 1'b0;
         long_ff  <= 1'b0;
      end else if (accept) begin
         // start the next word clean after its last character
         if (req_last_char) begin
            count_ff <= '0;
            bad_ff   <= 1'b0;
            long_ff  <= 1'b0;
         end else begin
            count_ff <= count_in;
            bad_ff   <= bad_in;
            long_ff  <= long_in;
         end
      end
   end

endmodule

FILE: rtl/shw_cmd_queue.sv
// ----------------------------------------------------------------------------
// shw_cmd_queue: command queue between front end and back end
// A short first-in first-out buffer of classified characters, so that
// intake and arithmetic stall independently.
// ----------------------------------------------------------------------------
module shw_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  shw_pkg::cmd_type wr_data,
   input  logic             rd_en,
   output shw_pkg::cmd_type rd_data,
   output logic             full,
   output logic             empty
);
   import shw_pkg::*;

   cmd_type              slot_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_AW:0]     count_ff, count_in;

   assign full    = (count_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (CMDQ_AW + 1)'(CMDQ_DEPTH))
      else $error("command queue holds more than its depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !empty)
      else $error("command queue read while empty");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!full || rd_en))
      else $error("command queue written while full");

endmodule

FILE: rtl/shw_back.sv
// ----------------------------------------------------------------------------
// shw_back: hash arithmetic back end
// Runs the per-character multiply-accumulate and the modular reductions on
// a two-lane remainder unit (hash lane, power lane), two dividend bits per
// cycle, and holds the finished word hash in an output register.
// ----------------------------------------------------------------------------
module shw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [shw_pkg::MOD_W-1:0]  modulus,
   input  logic                       q_empty,
   input  shw_pkg::cmd_type           q_head,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [shw_pkg::HASH_W-1:0] rsp_word_hash,
   output logic                       rsp_bad_character,
   output logic                       rsp_word_too_long
);
   import shw_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PREP_A = 8'b0000_0010,
      ST_RED_A  = 8'b0000_0100,
      ST_PREP_B = 8'b0000_1000,
      ST_RED_B  = 8'b0001_0000,
      ST_PREP_F = 8'b0010_0000,
      ST_RED_F  = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } back_state_type;

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [HASH_W-1:0]    h_ff, h_in;
   logic [HASH_W-1:0]    p_ff, p_in;
   logic [DIV_W-1:0]     div_h_ff, div_h_in;
   logic [DIV_W-1:0]     div_p_ff, div_p_in;
   logic [MOD_W-1:0]     rem_h_ff, rem_h_in;
   logic [MOD_W-1:0]     rem_p_ff, rem_p_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 out_valid_ff, out_valid_in;
   logic [HASH_W-1:0]    out_hash_ff;
   logic                 out_bad_ff;
   logic                 out_long_ff;

   logic [3:0]           mul_a;
   logic [HASH_W+3:0]    mul_prod;
   logic [MOD_W-1:0]     rem_h_mid, rem_h_nx;
   logic [MOD_W-1:0]     rem_p_mid, rem_p_nx;
   logic                 out_load;
   logic                 reducing;

   // one restoring remainder step: bring in one dividend bit, subtract if it fits
   function automatic logic [MOD_W-1:0] rem_step(input logic [MOD_W-1:0] rem,
                                                 input logic             din,
                                                 input logic [MOD_W-1:0] m);
      logic [MOD_W:0] t;
      t = {rem, din};
      if (t >= {1'b0, m}) begin
         t = t - {1'b0, m};
      end
      return t[MOD_W-1:0];
   endfunction

   assign rem_h_mid = rem_step(rem_h_ff, div_h_ff[DIV_W-1], modulus);
   assign rem_h_nx  = rem_step(rem_h_mid, div_h_ff[DIV_W-2], modulus);
   assign rem_p_mid = rem_step(rem_p_ff, div_p_ff[DIV_W-1], modulus);
   assign rem_p_nx  = rem_step(rem_p_mid, div_p_ff[DIV_W-2], modulus);

   // shared multiplier: low part in the first half, high part in the second
   assign mul_a    = (state_ff == ST_PREP_A) ? {1'b0, cmd_ff.code_low} : cmd_ff.code_high;
   assign mul_prod = (HASH_W + 4)'(mul_a) * (HASH_W + 4)'(p_ff);

   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign out_load = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_pop);
   assign reducing = (state_ff == ST_RED_A) || (state_ff == ST_RED_B) ||
                     (state_ff == ST_RED_F);

   assign rsp_empty         = !out_valid_ff;
   assign rsp_word_hash     = out_hash_ff;
   assign rsp_bad_character = out_bad_ff;
   assign rsp_word_too_long = out_long_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      h_in         = h_ff;
      p_in         = p_ff;
      div_h_in     = div_h_ff;
      div_p_in     = div_p_ff;
      rem_h_in     = rem_h_ff;
      rem_p_in     = rem_p_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;

      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               cmd_in = q_head;
               if (q_head.do_hash) begin
                  state_in = ST_PREP_A;
               end else if (q_head.last) begin
                  state_in = ST_PREP_F;
               end
            end
         end
         ST_PREP_A, ST_PREP_B: begin
            div_h_in = DIV_W'(mul_prod) + DIV_W'(h_ff);
            div_p_in = DIV_W'({p_ff, 3'b000});
            rem_h_in = '0;
            rem_p_in = '0;
            step_in  = STEP_W'(RED_STEPS - 1);
            state_in = (state_ff == ST_PREP_A) ? ST_RED_A : ST_RED_B;
         end
         ST_PREP_F: begin
            div_h_in = DIV_W'(h_ff);
            div_p_in = '0;
            rem_h_in = '0;
            rem_p_in = '0;
            step_in  = STEP_W'(RED_STEPS - 1);
            state_in = ST_RED_F;
         end
         ST_RED_A, ST_RED_B, ST_RED_F: begin
            div_h_in = {div_h_ff[DIV_W-3:0], 2'b00};
            div_p_in = {div_p_ff[DIV_W-3:0], 2'b00};
            rem_h_in = rem_h_nx;
            rem_p_in = rem_p_nx;
            step_in  = step_ff - 1'b1;
            if (step_ff == '0) begin
               if (state_ff == ST_RED_F) begin
                  state_in = ST_EMIT;
               end else begin
                  h_in = rem_h_nx[HASH_W-1:0];
                  p_in = rem_p_nx[HASH_W-1:0];
                  if (state_ff == ST_RED_A) begin
                     state_in = ST_PREP_B;
                  end else if (cmd_ff.last) begin
                     state_in = ST_PREP_F;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register is free, then start a new word
            if (out_load) begin
               out_valid_in = 1'b1;
               h_in         = '0;
               p_in         = POWER_INIT;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= '0;
         p_ff         <= POWER_INIT;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         p_ff         <= p_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      div_h_ff <= div_h_in;
      div_p_ff <= div_p_in;
      rem_h_ff <= rem_h_in;
      rem_p_ff <= rem_p_in;
      if (out_load) begin
         out_hash_ff <= rem_h_ff[HASH_W-1:0];
         out_bad_ff  <= cmd_ff.bad;
         out_long_ff <= cmd_ff.too_long;
      end
   end

   a_word_restart: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (h_ff == '0) && (p_ff == POWER_INIT) && !rsp_empty)
      else $error("word state not restarted after a result was loaded");

   a_step_countdown: assert property (@(posedge clock) disable iff (reset)
      (reducing && (step_ff != '0)) |=>
         (state_ff == $past(state_ff)) && (step_ff == $past(step_ff) - 1'b1))
      else $error("remainder unit left its pass early");

   a_result_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && (state_ff != ST_EMIT)) |=> rsp_empty)
      else $error("result still shown after its transaction");

endmodule

FILE: rtl/spell_word_hash.sv
// ----------------------------------------------------------------------------
// spell_word_hash: word hash for a spelling-list lookup
// One character per transaction in, one hash per word out.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   request  | req_push/req_full, char_code, last_char | in
//   response | rsp_pop/rsp_empty, word_hash, flags     | out
//   csr      | csr_valid/csr_ready, csr_data (modulus) | in
//
// A coded character passes through the back end as a queue pop, two
// multiply-accumulate setups and two passes of the two-lane
// remainder unit, which sets the rate. Characters without a code or past
// the length limit take only the queue pop. The end of a word adds the
// final reduction and the load of the result register.
// A four-entry command queue keeps intake running while the back end works;
// the back end holds a finished word until the result register is free.
// Reset is synchronous; it loads the modulus 134217689, no clearing pass.
// ----------------------------------------------------------------------------
module spell_word_hash (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_char_code,
   input  logic                       req_last_char,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [shw_pkg::HASH_W-1:0] rsp_word_hash,
   output logic                       rsp_bad_character,
   output logic                       rsp_word_too_long,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [shw_pkg::MOD_W-1:0]  csr_data
);
   import shw_pkg::*;

   logic [MOD_W-1:0] mod_ff, mod_in;
   logic [MOD_W-1:0] mod_eff;
   logic             q_full, q_empty, q_wr, q_pop;
   cmd_type          q_entry, q_head;

   assign csr_ready = 1'b1;
   assign mod_in    = (csr_valid && csr_ready) ? csr_data : mod_ff;

   // clamp the modulus into its legal range
   always_comb begin
      if (mod_ff < MOD_MIN) begin
         mod_eff = MOD_MIN;
      end else if (mod_ff > MOD_MAX) begin
         mod_eff = MOD_MAX;
      end else begin
         mod_eff = mod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_RESET;
      end else begin
         mod_ff <= mod_in;
      end
   end

   shw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (q_full),
      .q_wr          (q_wr),
      .q_entry       (q_entry)
   );

   shw_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr),
      .wr_data (q_entry),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   shw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .modulus           (mod_eff),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_word_hash     (rsp_word_hash),
      .rsp_bad_character (rsp_bad_character),
      .rsp_word_too_long (rsp_word_too_long)
   );

endmodule

FILE: sim/tb_spell_word_hash.sv
// ----------------------------------------------------------------------------
// tb_spell_word_hash: self-checking bench for the spelling word hash
// Feeds words one character per transaction, tracks the running hash, power,
// length and flags of each word in a scoreboard, and compares every popped
// word hash and flag pair with the prediction. The modulus is rewritten
// between words and once inside a word; sender and receiver idle at random,
// and the receiver holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_spell_word_hash;

   import shw_pkg::*;

   localparam int SETTLE_CYCLES = 200;
   localparam int HOLD_CYCLES   = 1500;
   localparam int ITEM_TARGET   = 950;
   localparam int FLOOD_AT      = 400;

   localparam logic [MOD_W-1:0] MOD_ALL_ONES = {MOD_W{1'b1}};

   // character codes from space to DEL, NO_CODE marks a gap
   localparam bit [7:0] CHAR_CODES [96] = '{
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd31,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd68,  8'd255, 8'd65,  8'd255,
      8'd2,   8'd25,  8'd20,  8'd35,  8'd54,  8'd61,  8'd40,  8'd39,
      8'd42,  8'd33,  8'd64,  8'd67,  8'd255, 8'd255, 8'd255, 8'd66,
      8'd255, 8'd60,  8'd43,  8'd30,  8'd5,   8'd16,  8'd47,  8'd18,
      8'd41,  8'd36,  8'd51,  8'd6,   8'd13,  8'd56,  8'd55,  8'd58,
      8'd49,  8'd12,  8'd59,  8'd46,  8'd21,  8'd32,  8'd63,  8'd34,
      8'd57,  8'd52,  8'd3,   8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd22,  8'd29,  8'd8,   8'd7,   8'd10,  8'd1,   8'd28,
      8'd11,  8'd62,  8'd37,  8'd48,  8'd15,  8'd50,  8'd9,   8'd4,
      8'd19,  8'd38,  8'd45,  8'd24,  8'd23,  8'd26,  8'd17,  8'd44,
      8'd27,  8'd14,  8'd53,  8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

   typedef struct {
      bit [HASH_W-1:0] word_hash;
      bit              bad_character;
      bit              word_too_long;
   } word_result_type;

   typedef enum int {WORD_CLEAN, WORD_NOISY} word_kind_type;

   class hash_board;
      bit [MOD_W-1:0]  modulus;
      bit [HASH_W-1:0] acc_hash;
      bit [HASH_W-1:0] acc_power;
      bit [4:0]        coded_count;
      bit              bad_seen;
      bit              long_seen;
      word_result_type pending_hashes[$];
      int              errors;

      function new();
         modulus = MOD_RESET;
         errors  = 0;
         start_word();
      endfunction

      function void start_word();
         acc_hash    = '0;
         acc_power   = HASH_W'(1) << (HASH_W - 8);
         coded_count = '0;
         bad_seen    = 1'b0;
         long_seen   = 1'b0;
      endfunction

      function void set_modulus(bit [MOD_W-1:0] value);
         modulus = value;
      endfunction

      function longint unsigned clamped_modulus();
         if (modulus < MOD_MIN) return longint'(MOD_MIN);
         if (modulus > MOD_MAX) return longint'(MOD_MAX);
         return longint'(modulus);
      endfunction

      function int pending_words();
         return pending_hashes.size();
      endfunction

      // fold one accepted character into the word, queue the hash on the last
      function void take_char(bit [7:0] ch, bit last);
         longint unsigned m;
         longint unsigned h;
         longint unsigned p;
         bit [7:0]        code;
         word_result_type res;
         m    = clamped_modulus();
         code = NO_CODE;
         if (ch >= 8'h20 && ch < 8'h80) code = CHAR_CODES[ch - 8'h20];
         if (code == NO_CODE) begin
            bad_seen = 1'b1;
         end else if (coded_count >= MAX_WORD_LEN) begin
            long_seen = 1'b1;
         end else begin
            h = acc_hash;
            p = acc_power;
            h = h + longint'(code[2:0]) * p;
            p = (p << 3) % m;
            h = h + longint'(code[7:3]) * p;
            p = (p << 3) % m;
            h = h % m;
            acc_hash    = HASH_W'(h);
            acc_power   = HASH_W'(p);
            coded_count = coded_count + 5'd1;
         end
         if (last) begin
            res.word_hash     = HASH_W'(longint'(acc_hash) % m);
            res.bad_character = bad_seen;
            res.word_too_long = long_seen;
            pending_hashes.push_back(res);
            start_word();
         end
      endfunction

      task report(string what, longint unsigned seen, longint unsigned wanted);
         $display("mismatch %s: got %0d, wanted %0d", what, seen, wanted);
         errors++;
      endtask

      task match_hash(bit [HASH_W-1:0] h, bit bad, bit too_long);
         word_result_type want;
         if (pending_hashes.size() == 0) begin
            report("word hash with no word pending", h, 0);
         end else begin
            want = pending_hashes.pop_front();
            if (h != want.word_hash) report("word_hash", h, want.word_hash);
            if (bad != want.bad_character) report("bad_character", bad, want.bad_character);
            if (too_long != want.word_too_long)
               report("word_too_long", too_long, want.word_too_long);
         end
      endtask

      task close_out();
         while (pending_hashes.size() != 0) begin
            report("word never returned", pending_hashes[0].word_hash, 0);
            void'(pending_hashes.pop_front());
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [7:0]          req_char_code = '0;
   logic                req_last_char = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [HASH_W-1:0]   rsp_word_hash;
   logic                rsp_bad_character;
   logic                rsp_word_too_long;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [MOD_W-1:0]    csr_data = '0;

   hash_board board = new();
   bit        hold_results = 1'b0;
   bit        send_quiet = 1'b0;
   bit        take_quiet = 1'b0;
   int        chars_sent = 0;

   spell_word_hash u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_char_code     (req_char_code),
      .req_last_char     (req_last_char),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_word_hash     (rsp_word_hash),
      .rsp_bad_character (rsp_bad_character),
      .rsp_word_too_long (rsp_word_too_long),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [7:0] coded_char();
      bit [7:0] c;
      c = 8'(($urandom_range(32, 127)));
      while (CHAR_CODES[c - 8'h20] == NO_CODE) c = 8'($urandom_range(32, 127));
      return c;
   endfunction

   function automatic bit [MOD_W-1:0] pick_modulus();
      case ($urandom_range(0, 7))
         0: return MOD_RESET;
         1: return MOD_W'($urandom_range(2, 1000));
         2: return MOD_W'($urandom);
         3: return MOD_MAX;
         4: return '0;
         5: return MOD_W'(1);
         6: return MOD_ALL_ONES;
         default: return MOD_MAX - MOD_W'($urandom_range(0, 1000));
      endcase
   endfunction

   // entered just after a rising edge; leaves on the edge that took the transaction
   task automatic send_char(bit [7:0] ch, bit last);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push      = 1'b1;
      req_char_code = ch;
      req_last_char = last;
      do @(posedge clock); while (req_full);
      board.take_char(ch, last);
      chars_sent++;
   endtask

   task automatic send_word(int len, word_kind_type kind);
      bit [7:0] ch;
      for (int i = 0; i < len; i++) begin
         ch = (kind == WORD_NOISY) ? 8'($urandom_range(0, 255)) : coded_char();
         send_char(ch, i == len - 1);
      end
   endtask

   // drop the push, wait for every word back, then let the back end settle
   task automatic drain_words();
      @(negedge clock);
      req_push = 1'b0;
      while (board.pending_words() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_modulus(bit [MOD_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      board.set_modulus(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin : take_results
      int stall;
      while (reset) @(negedge clock);
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         stall = take_quiet ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         do @(posedge clock); while (rsp_empty);
         board.match_hash(rsp_word_hash, rsp_bad_character, rsp_word_too_long);
         if ($urandom_range(0, 19) == 0) take_quiet = !take_quiet;
         @(negedge clock);
      end
   end

   initial begin : run_words
      bit flooded;
      int sel;
      flooded = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset modulus; last character has no code
      send_char("A", 1'b0);
      send_char("z", 1'b0);
      send_char("~", 1'b1);
      // bytes outside the table, a gap inside it and the byte extremes
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'h7F, 1'b0);
      send_char("0", 1'b1);
      // lowest and highest codes
      send_char("&", 1'b1);
      send_char(",", 1'b1);
      // change the modulus in the middle of a word
      send_char("a", 1'b0);
      send_char("b", 1'b0);
      drain_words();
      write_modulus(MOD_W'(1000));
      send_char("c", 1'b1);
      // moduli below the floor, above and at the ceiling, and just above the floor
      drain_words();
      write_modulus('0);
      send_char("x", 1'b0);
      send_char("y", 1'b1);
      drain_words();
      write_modulus(MOD_W'(1));
      send_char("q", 1'b1);
      drain_words();
      write_modulus(MOD_ALL_ONES);
      send_char("Q", 1'b1);
      drain_words();
      write_modulus(MOD_MAX);
      send_char("m", 1'b1);
      drain_words();
      write_modulus(MOD_W'(3));
      send_char("M", 1'b1);

      while (chars_sent < ITEM_TARGET) begin
         drain_words();
         write_modulus(pick_modulus());
         send_quiet = ($urandom_range(0, 3) == 0);
         if (!flooded && chars_sent >= FLOOD_AT) begin
            // short words while the receiver holds off fill the block up
            flooded = 1'b1;
            hold_results = 1'b1;
            repeat (30) send_word(1, WORD_CLEAN);
         end else begin
            repeat ($urandom_range(6, 16)) begin
               sel = $urandom_range(0, 99);
               if (sel < 6)
                  send_word($urandom_range(MAX_WORD_LEN - 1, MAX_WORD_LEN + 3), WORD_CLEAN);
               else if (sel < 82)
                  send_word($urandom_range(1, 8), WORD_CLEAN);
               else
                  send_word($urandom_range(1, 8), WORD_NOISY);
            end
         end
      end

      drain_words();
      board.close_out();
      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: spell_word_hash.f
rtl/shw_pkg.sv
rtl/shw_front.sv
rtl/shw_cmd_queue.sv
rtl/shw_back.sv
rtl/spell_word_hash.sv
sim/tb_spell_word_hash.sv
